// ----- rtl/core/lzwc_pkg.sv -----
// Shared constants, payload types and dictionary chain types of the LZW byte compressor.
package lzwc_pkg;

	localparam int CODE_BITS     = 12;
	localparam int LITERAL_CODES = 256;
	localparam int CODE_SPACE    = 1 << CODE_BITS;
	localparam int DICT_DEPTH    = CODE_SPACE - LITERAL_CODES;
	localparam int KEY_BITS      = CODE_BITS + 8;
	localparam int NF_BITS       = CODE_BITS + 1;
	localparam int LIMIT_BITS    = 13;
	localparam int LIMIT_RESET   = 4096;
	localparam int CMP_BITS      = (NF_BITS > LIMIT_BITS) ? NF_BITS : LIMIT_BITS;

	localparam int CELL_ENTRIES  = 32;
	localparam int ENTRY_BITS    = $clog2(CELL_ENTRIES);
	localparam int NUM_CELLS     = DICT_DEPTH / CELL_ENTRIES;
	localparam int CELL_ID_BITS  = CODE_BITS - ENTRY_BITS;

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code_out;
		logic                 last_code;
	} out_item_t;

	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [CODE_BITS-1:0] code;
		logic [KEY_BITS-1:0]  key;
	} query_t;

	typedef struct packed {
		logic                 en;
		logic [CODE_BITS-1:0] slot;
		logic [KEY_BITS-1:0]  key;
	} dict_wr_t;

endpackage

// ----- rtl/core/lzw_byte_compressor.sv -----
// Top level of the LZW byte compressor: prefix control, dictionary chain and output queue.
//
//   port group   direction  handshake           payload
//   src          in         src_valid/ready     in_item_t   (byte_in, end_of_stream)
//   dst          out        dst_valid/ready     out_item_t  (code_out, last_code)
//   cfg          in         cfg_we, no wait     cfg_wdata   (code_limit)
//
// A byte that starts a stream, or arrives while the dictionary is empty, is finished in the
// cycle it is accepted. Any other byte is looked up in the dictionary chain: the
// lookup visits one dictionary cell per cycle, then the prefix and dictionary are updated.
// Reset clears the prefix, the free code counter and the queue; dictionary contents are not
// cleared. A new request is taken only while the output queue has room for two codes.
module lzw_byte_compressor
	import lzwc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  in_item_t              src_data,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output out_item_t             dst_data,
	input  logic                  cfg_we,
	input  logic [LIMIT_BITS-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

	state_t                   state_q;
	logic [LIMIT_BITS-1:0]    code_limit_q;
	logic [CODE_BITS-1:0]     prefix_q;
	logic                     prefix_valid_q;
	logic [NF_BITS-1:0]       nf_q;
	logic [7:0]               byte_q;
	logic                     last_q;

	out_item_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	logic                     accept;
	logic                     pop;
	logic [CODE_BITS-1:0]     used_slots;
	logic                     need_search;
	logic                     search_done;
	logic                     resolve_en;
	logic                     no_prefix;
	logic                     hit;
	logic [7:0]               res_byte;
	logic                     res_last;
	logic                     room;
	logic                     emit_prefix;
	logic                     emit_last;
	logic [CODE_BITS-1:0]     new_prefix;
	logic [1:0]               push_cnt;
	out_item_t                item0;
	out_item_t                item1;
	query_t                   query_in;
	query_t                   query_out;
	dict_wr_t                 wr;

	assign used_slots  = CODE_BITS'(nf_q - NF_BITS'(LITERAL_CODES));
	assign src_ready   = (state_q == ST_IDLE) && (cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign accept      = src_valid && src_ready;
	assign need_search = prefix_valid_q && (used_slots != '0);
	assign search_done = (state_q == ST_SEARCH) && query_out.valid;
	assign resolve_en  = (accept && !need_search) || search_done;
	assign no_prefix   = !prefix_valid_q;
	assign hit         = search_done && query_out.found;
	assign res_byte    = (state_q == ST_SEARCH) ? byte_q : src_data.byte_in;
	assign res_last    = (state_q == ST_SEARCH) ? last_q : src_data.end_of_stream;

	assign room = (nf_q < NF_BITS'(CODE_SPACE))
		&& (CMP_BITS'(nf_q) < CMP_BITS'(code_limit_q));

	assign emit_prefix = resolve_en && !no_prefix && !hit;
	assign emit_last   = resolve_en && res_last;
	assign new_prefix  = hit ? query_out.code : CODE_BITS'(res_byte);
	assign push_cnt    = {1'b0, emit_prefix} + {1'b0, emit_last};

	assign item0.code_out  = emit_prefix ? prefix_q : new_prefix;
	assign item0.last_code = !emit_prefix;
	assign item1.code_out  = new_prefix;
	assign item1.last_code = 1'b1;

	assign wr.en   = emit_prefix && room;
	assign wr.slot = used_slots;
	assign wr.key  = {prefix_q, res_byte};

	assign query_in.valid = accept && need_search;
	assign query_in.found = 1'b0;
	assign query_in.code  = '0;
	assign query_in.key   = {prefix_q, src_data.byte_in};

	lzwc_dict u_dict (
		.clk       (clk),
		.arst_n    (arst_n),
		.used_slots(used_slots),
		.wr        (wr),
		.query_in  (query_in),
		.query_out (query_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			code_limit_q   <= LIMIT_BITS'(LIMIT_RESET);
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			nf_q           <= NF_BITS'(LITERAL_CODES);
		end else begin
			if (cfg_we) begin
				code_limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && need_search) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (search_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (resolve_en) begin
				if (res_last) begin
					prefix_q       <= '0;
					prefix_valid_q <= 1'b0;
					nf_q           <= NF_BITS'(LITERAL_CODES);
				end else begin
					prefix_q       <= new_prefix;
					prefix_valid_q <= 1'b1;
					if (wr.en) begin
						nf_q <= nf_q + NF_BITS'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= src_data.byte_in;
			last_q <= src_data.end_of_stream;
		end
	end

	assign pop       = dst_valid && dst_ready;
	assign dst_valid = (cnt_q != '0);
	assign dst_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(pop);
			cnt_q    <= cnt_q + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= item0;
		end
		if (push_cnt == 2'd2) begin
			fifo_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= item1;
		end
	end

endmodule

// ----- rtl/core/lzwc_cell.sv -----
// One dictionary cell: a slice of dictionary entries that checks a passing lookup and hands it on.
module lzwc_cell
	import lzwc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CELL_ID_BITS-1:0] cell_id,
	input  logic [CODE_BITS-1:0]    used_slots,
	input  dict_wr_t                wr,
	input  query_t                  query_in,
	output query_t                  query_out
);

	logic [KEY_BITS-1:0]   entry_q [CELL_ENTRIES];
	logic                  valid_q;
	logic                  found_q;
	logic [CODE_BITS-1:0]  code_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  hit;
	logic [ENTRY_BITS-1:0] hit_idx;

	always_comb begin
		logic [CODE_BITS-1:0] slot;
		hit     = 1'b0;
		hit_idx = '0;
		slot    = '0;
		for (int k = 0; k < CELL_ENTRIES; k++) begin
			slot = {cell_id, ENTRY_BITS'(k)};
			if ((slot < used_slots) && (entry_q[k] == query_in.key)) begin
				hit     = 1'b1;
				hit_idx = ENTRY_BITS'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.slot[CODE_BITS-1:ENTRY_BITS] == cell_id)) begin
			entry_q[wr.slot[ENTRY_BITS-1:0]] <= wr.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= query_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		found_q <= query_in.found | hit;
		code_q  <= query_in.found ? query_in.code
			: (CODE_BITS'(LITERAL_CODES) + {cell_id, hit_idx});
		key_q   <= query_in.key;
	end

	assign query_out.valid = valid_q;
	assign query_out.found = found_q;
	assign query_out.code  = code_q;
	assign query_out.key   = key_q;

endmodule

// ----- rtl/core/lzwc_dict.sv -----
// Dictionary as a row of cells that a lookup walks through, one cell per cycle.
module lzwc_dict
	import lzwc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CODE_BITS-1:0] used_slots,
	input  dict_wr_t             wr,
	input  query_t               query_in,
	output query_t               query_out
);

	query_t link [NUM_CELLS+1];

	assign link[0] = query_in;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lzwc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (CELL_ID_BITS'(i)),
			.used_slots(used_slots),
			.wr        (wr),
			.query_in  (link[i]),
			.query_out (link[i+1])
		);
	end

	assign query_out = link[NUM_CELLS];

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the LZW byte compressor with a predictor, random idling and stalls.
`timescale 1ns / 100ps

module tb_top
	import lzwc_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int LONG_HOLD      = 3000;

	typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_ready;
	in_item_t              src_data = '0;
	logic                  dst_valid;
	logic                  dst_ready = 1'b0;
	out_item_t             dst_data;
	logic                  cfg_we = 1'b0;
	logic [LIMIT_BITS-1:0] cfg_wdata = LIMIT_BITS'(LIMIT_RESET);

	in_item_t  pending_items[$];
	out_item_t pending_codes[$];

	logic [KEY_BITS-1:0]   dict_key[DICT_DEPTH];
	logic [CODE_BITS-1:0]  prefix = '0;
	bit                    have_prefix = 1'b0;
	int unsigned           free_code = LITERAL_CODES;
	logic [LIMIT_BITS-1:0] code_limit_now = LIMIT_BITS'(LIMIT_RESET);

	int unsigned bytes_sent = 0;
	int unsigned streams_sent = 0;
	int unsigned codes_checked = 0;
	int unsigned mismatches = 0;
	int unsigned limit_settings = 0;
	int unsigned quiet_cycles = 0;
	int unsigned long_hold_asks = 0;
	int unsigned long_hold_done = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	rx_mode_t    ready_mode = RX_ALWAYS;
	logic [15:0] ready_pattern = 16'hA5C3;
	out_item_t   want;

	lzw_byte_compressor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void lzw_encode_byte(in_item_t item);
		logic [KEY_BITS-1:0] key;
		int unsigned used;
		int unsigned hit;
		int unsigned cap;
		int unsigned k;
		bit found;
		out_item_t emitted;
		found = 1'b0;
		hit = 0;
		if (!have_prefix) begin
			prefix = CODE_BITS'(item.byte_in);
			have_prefix = 1'b1;
		end else begin
			key = {prefix, item.byte_in};
			used = free_code - LITERAL_CODES;
			if (used > DICT_DEPTH)
				used = DICT_DEPTH;
			for (k = 0; k < used && !found; k++) begin
				if (dict_key[k] == key) begin
					found = 1'b1;
					hit = k;
				end
			end
			if (found) begin
				prefix = CODE_BITS'(LITERAL_CODES + hit);
			end else begin
				emitted.code_out = prefix;
				emitted.last_code = 1'b0;
				pending_codes.insert(pending_codes.size(), emitted);
				cap = (code_limit_now < CODE_SPACE) ? code_limit_now : CODE_SPACE;
				if (free_code < cap) begin
					if (free_code - LITERAL_CODES < DICT_DEPTH)
						dict_key[free_code - LITERAL_CODES] = key;
					free_code++;
				end
				prefix = CODE_BITS'(item.byte_in);
			end
		end
		if (item.end_of_stream) begin
			emitted.code_out = prefix;
			emitted.last_code = 1'b1;
			pending_codes.insert(pending_codes.size(), emitted);
			prefix = '0;
			have_prefix = 1'b0;
			free_code = LITERAL_CODES;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (src_valid && src_ready) begin
				bytes_sent++;
				if (src_data.end_of_stream)
					streams_sent++;
				lzw_encode_byte(src_data);
			end
			if (!src_valid || src_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					src_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					src_valid <= 1'b1;
					src_data <= pending_items.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
			hold_left <= 0;
			mode_left <= 0;
		end else begin
			if (dst_valid && dst_ready) begin
				codes_checked++;
				if (pending_codes.size() == 0) begin
					$error("unexpected code: code_out %0d, last_code %0b",
						dst_data.code_out, dst_data.last_code);
					mismatches++;
				end else begin
					want = pending_codes.pop_front();
					if (dst_data.code_out !== want.code_out) begin
						$error("code_out: expected %0d, got %0d", want.code_out,
							dst_data.code_out);
						mismatches++;
					end
					if (dst_data.last_code !== want.last_code) begin
						$error("last_code: expected %0b, got %0b", want.last_code,
							dst_data.last_code);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				dst_ready <= 1'b0;
			end else if (long_hold_done < long_hold_asks) begin
				long_hold_done <= long_hold_done + 1;
				hold_left <= LONG_HOLD;
				dst_ready <= 1'b0;
			end else if (mode_left == 0) begin
				mode_left <= $urandom_range(20, 200);
				ready_mode <= rx_mode_t'($urandom_range(0, 3));
				ready_pattern <= 16'($urandom);
				dst_ready <= 1'b1;
			end else begin
				mode_left <= mode_left - 1;
				ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
				case (ready_mode)
					RX_ALWAYS: begin
						dst_ready <= 1'b1;
					end
					RX_MOSTLY: begin
						dst_ready <= ($urandom_range(0, 3) != 0);
					end
					RX_RARELY: begin
						dst_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						dst_ready <= ready_pattern[15];
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && src_ready) || (dst_valid && dst_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void push_byte(logic [7:0] value, bit eos);
		in_item_t item;
		item.byte_in = value;
		item.end_of_stream = eos;
		pending_items.insert(pending_items.size(), item);
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || src_valid || pending_codes.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_code_limit(logic [LIMIT_BITS-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		code_limit_now = value;
		limit_settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_stream(int unsigned len, bit close);
		int unsigned kind;
		int unsigned i;
		logic [7:0] base;
		logic [7:0] value;
		kind = $urandom_range(0, 9);
		base = 8'($urandom);
		for (i = 0; i < len; i++) begin
			if (kind < 5)
				value = base + 8'($urandom_range(0, 2));
			else if (kind < 9)
				value = 8'($urandom);
			else
				value = base;
			push_byte(value, close && (i == len - 1));
		end
	endtask

	task automatic queue_streams(int unsigned count);
		int unsigned total;
		int unsigned len;
		int unsigned pick;
		total = 0;
		while (total < count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = 1;
			else if (pick == 1)
				len = $urandom_range(60, 120);
			else
				len = $urandom_range(2, 30);
			if (len > count - total)
				len = count - total;
			queue_stream(len, 1'b1);
			total += len;
		end
	endtask

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_code_limit(LIMIT_BITS'(LIMIT_RESET));
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		for (i = 0; i < 7; i++)
			push_byte((i % 2) ? 8'h42 : 8'h41, i == 6);
		for (i = 0; i < 5; i++)
			push_byte(8'h00, i == 4);
		for (i = 0; i < 4; i++)
			push_byte((i % 2) ? 8'h00 : 8'hFF, i == 3);
		for (i = 0; i < 4; i++)
			push_byte((i % 2) ? 8'h7F : 8'h80, i == 3);

		set_code_limit(LIMIT_BITS'(LITERAL_CODES + 1));
		queue_streams(120);
		set_code_limit('0);
		queue_streams(100);
		set_code_limit('1);
		queue_streams(150);
		set_code_limit(LIMIT_BITS'(300));
		queue_streams(150);
		queue_stream(12, 1'b0);
		set_code_limit(LIMIT_BITS'($urandom_range(LITERAL_CODES + 1, 600)));
		queue_streams(130);
		set_code_limit(LIMIT_BITS'(LIMIT_RESET));
		long_hold_asks++;
		queue_streams(130);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d streams over %0d code limit settings; checked %0d codes.",
			bytes_sent, streams_sent, limit_settings, codes_checked);
		$display("Included single-byte streams, full dictionaries and a %0d-cycle output stall.",
			LONG_HOLD);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
